// File: src/auo_pkg.sv
// Shared constants and types for the multi-turn angle unwrap odometer.
package auo_pkg;

   localparam int ANGLE_W   = 12;
   localparam int THRESH_W  = 12;
   localparam int OFFSET_W  = 15;
   localparam int ACC_W     = 32;
   localparam int POS_W     = 16;
   localparam int DIGIT_W   = 8;
   localparam int FRAME_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_OFFSET = 2'd1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd3000;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 15'd20000;

   localparam logic signed [13:0] TURN_COUNTS = 14'sd4096;

   // Scaling: position = acc * 1000 / 25129. Magnitudes above MAG_CLAMP
   // saturate the position anyway, so the multiply only needs 19 bits in.
   localparam int MAG_W   = 19;
   localparam int PROD_W  = 29;
   localparam int QUOT_W  = 15;
   localparam logic [MAG_W-1:0] MAG_CLAMP = 19'd524287;
   localparam logic [9:0] SCALE_MUL = 10'd1000;
   localparam int SCALE_SHIFT = 44;
   localparam int RECIP_W = 30;
   localparam logic [RECIP_W-1:0] SCALE_RECIP =
      RECIP_W'(((64'd1 << SCALE_SHIFT) + 64'd25128) / 64'd25129);
   localparam logic [QUOT_W-1:0] POS_LIMIT = 15'd20000;
   localparam logic [FRAME_W-1:0] FRAME_MAX = 16'd51199;

   // Digit split: framed / 200 = (framed >> 3) / 25, done by reciprocal.
   localparam int DIGIT_SHIFT = 18;
   localparam logic [13:0] DIGIT_RECIP = 14'd10486;
   localparam logic [DIGIT_W-1:0] DIGIT_BASE = 8'd200;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [FRAME_W-1:0]      framed;
   } scaled_type;

endpackage

// File: src/auo_if.sv
// Handshake channel interfaces: sample input, result output and register writes.
interface auo_req_if;
   logic                          valid;
   logic                          ready;
   logic [auo_pkg::ANGLE_W-1:0]   angle_sample;
   modport source (output valid, output angle_sample, input ready);
   modport sink (input valid, input angle_sample, output ready);
endinterface

interface auo_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [auo_pkg::POS_W-1:0]   position;
   logic [auo_pkg::DIGIT_W-1:0]        frame_low_digit;
   logic [auo_pkg::DIGIT_W-1:0]        frame_high_digit;
   modport source (output valid, output position, output frame_low_digit,
                   output frame_high_digit, input ready);
   modport sink (input valid, input position, input frame_low_digit,
                 input frame_high_digit, output ready);
endinterface

interface auo_csr_if;
   logic                            valid;
   logic                            ready;
   logic [auo_pkg::CSR_IDX_W-1:0]   index;
   logic [auo_pkg::CSR_DAT_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/auo_unwrap.sv
// Unwrap stage: sample difference, wrap correction and saturating turn accumulator.
module auo_unwrap (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [auo_pkg::THRESH_W-1:0]        thresh,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [auo_pkg::ANGLE_W-1:0]         in_sample,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [auo_pkg::ACC_W-1:0]    out_acc
);
   logic                                primed_ff;
   logic [auo_pkg::ANGLE_W-1:0]         prev_ff;
   logic signed [auo_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic                                valid_ff;
   logic signed [auo_pkg::ACC_W-1:0]    res_ff;
   logic signed [12:0]                  diff;
   logic [12:0]                         diff_abs;
   logic signed [13:0]                  delta;
   logic signed [32:0]                  sum;
   logic                                accept;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_acc   = res_ff;

   always_comb begin
      diff     = $signed({1'b0, in_sample}) - $signed({1'b0, prev_ff});
      diff_abs = diff[12] ? 13'(-diff) : 13'(diff);
      if (diff == 13'sd0) begin
         delta = 14'sd0;
      end else if (diff_abs[11:0] < thresh) begin
         delta = {diff[12], diff};
      end else if (!diff[12]) begin
         delta = {diff[12], diff} - auo_pkg::TURN_COUNTS;
      end else begin
         delta = {diff[12], diff} + auo_pkg::TURN_COUNTS;
      end
      sum = {acc_ff[31], acc_ff} + {{19{delta[13]}}, delta};
      if (!primed_ff) begin
         acc_in = '0;
      end else if (sum[32] != sum[31]) begin
         // Overflow: clamp toward the sign of the true sum.
         acc_in = sum[32] ? {1'b1, {(auo_pkg::ACC_W-1){1'b0}}}
                          : {1'b0, {(auo_pkg::ACC_W-1){1'b1}}};
      end else begin
         acc_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         prev_ff   <= '0;
         acc_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            primed_ff <= 1'b1;
            prev_ff   <= in_sample;
            acc_ff    <= acc_in;
         end
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= acc_in;
      end
   end
endmodule

// File: src/auo_scale.sv
// Scaling pipeline: accumulator to saturated position and clamped offset position.
module auo_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [auo_pkg::OFFSET_W-1:0]        offset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [auo_pkg::ACC_W-1:0]    in_acc,
   output logic                                out_valid,
   input  logic                                out_ready,
   output auo_pkg::scaled_type                 out_data
);
   logic v2_ff, v3_ff, v4_ff;
   logic r2, r3, r4;

   logic                                neg2_ff, neg3_ff;
   logic [auo_pkg::PROD_W-1:0]          prod2_ff;
   logic [auo_pkg::QUOT_W-1:0]          quot3_ff;
   auo_pkg::scaled_type                 data4_ff;

   logic [32:0]                         acc_abs;
   logic [auo_pkg::MAG_W-1:0]           mag;
   logic [auo_pkg::PROD_W-1:0]          prod_in;
   logic [auo_pkg::PROD_W+auo_pkg::RECIP_W-1:0] recip_prod;
   logic [auo_pkg::QUOT_W-1:0]          quot_sat;
   logic signed [auo_pkg::POS_W-1:0]    pos;
   logic signed [16:0]                  framed_s;
   auo_pkg::scaled_type                 data_in;

   assign r4        = !v4_ff || out_ready;
   assign r3        = !v3_ff || r4;
   assign r2        = !v2_ff || r3;
   assign in_ready  = r2;
   assign out_valid = v4_ff;
   assign out_data  = data4_ff;

   always_comb begin
      acc_abs = in_acc[31] ? 33'(-{in_acc[31], in_acc}) : {1'b0, in_acc};
      mag = (acc_abs > 33'(auo_pkg::MAG_CLAMP)) ? auo_pkg::MAG_CLAMP
                                                : acc_abs[auo_pkg::MAG_W-1:0];
      prod_in = auo_pkg::PROD_W'(mag * auo_pkg::SCALE_MUL);
   end

   assign recip_prod = prod2_ff * auo_pkg::SCALE_RECIP;

   always_comb begin
      quot_sat = (quot3_ff > auo_pkg::POS_LIMIT) ? auo_pkg::POS_LIMIT : quot3_ff;
      pos = neg3_ff ? -$signed({1'b0, quot_sat}) : $signed({1'b0, quot_sat});
      framed_s = {pos[15], pos} + $signed({2'b00, offset});
      data_in.pos = pos;
      if (framed_s[16]) begin
         data_in.framed = '0;
      end else if (framed_s[15:0] > auo_pkg::FRAME_MAX) begin
         data_in.framed = auo_pkg::FRAME_MAX;
      end else begin
         data_in.framed = framed_s[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r2) v2_ff <= in_valid;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r2 && in_valid) begin
         neg2_ff  <= in_acc[31];
         prod2_ff <= prod_in;
      end
      if (r3 && v2_ff) begin
         neg3_ff  <= neg2_ff;
         quot3_ff <= recip_prod[auo_pkg::SCALE_SHIFT +: auo_pkg::QUOT_W];
      end
      if (r4 && v3_ff) begin
         data4_ff <= data_in;
      end
   end
endmodule

// File: src/auo_digits.sv
// Digit split of the offset position into base-200 digits, with the result register.
module auo_digits (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  auo_pkg::scaled_type     in_data,
   auo_rsp_if.source               rsp
);
   logic                           v5_ff, v6_ff;
   logic                           r5, r6;
   auo_pkg::scaled_type            data5_ff;
   logic [auo_pkg::DIGIT_W-1:0]    high5_ff;
   logic [25:0]                    recip_prod;
   logic [auo_pkg::FRAME_W-1:0]    high_times_base;
   logic [auo_pkg::FRAME_W-1:0]    low_full;
   logic signed [auo_pkg::POS_W-1:0] pos6_ff;
   logic [auo_pkg::DIGIT_W-1:0]    low6_ff, high6_ff;

   assign r6       = !v6_ff || rsp.ready;
   assign r5       = !v5_ff || r6;
   assign in_ready = r5;

   assign recip_prod = 26'(in_data.framed[auo_pkg::FRAME_W-1:3] * auo_pkg::DIGIT_RECIP);
   assign high_times_base = 16'(high5_ff * auo_pkg::DIGIT_BASE);
   assign low_full = data5_ff.framed - high_times_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (r5) v5_ff <= in_valid;
         if (r6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r5 && in_valid) begin
         data5_ff <= in_data;
         high5_ff <= recip_prod[auo_pkg::DIGIT_SHIFT +: auo_pkg::DIGIT_W];
      end
      if (r6 && v5_ff) begin
         pos6_ff  <= data5_ff.pos;
         low6_ff  <= low_full[auo_pkg::DIGIT_W-1:0];
         high6_ff <= high5_ff;
      end
   end

   assign rsp.valid            = v6_ff;
   assign rsp.position         = pos6_ff;
   assign rsp.frame_low_digit  = low6_ff;
   assign rsp.frame_high_digit = high6_ff;
endmodule

// File: src/angle_unwrap_odometer.sv
// Top level of the multi-turn angle unwrap odometer.
// Takes one 12-bit absolute angle sample per beat and returns one result beat per sample:
// the unwrapped, scaled and saturated position and its offset form split into base-200
// digits. One sample is accepted every clock cycle unless a stalled result has filled the
// pipeline; each result passes through the six stages (unwrap and accumulate, two scaling
// multiplies, saturate and offset, digit reciprocal, remainder). The turn accumulator is
// updated in the first stage as the sample is accepted, so back-to-back samples chain
// without waiting. A stalled result only holds up the pipeline once every stage is full.
// Register writes are always accepted and should be issued while the block is idle.
module angle_unwrap_odometer (
   input  logic       clock,
   input  logic       reset,
   auo_req_if.sink    req_ch,
   auo_rsp_if.source  rsp_ch,
   auo_csr_if.sink    csr_ch
);
   logic [auo_pkg::THRESH_W-1:0]       thresh_ff;
   logic [auo_pkg::OFFSET_W-1:0]       offset_ff;
   logic                               unw_valid, unw_ready;
   logic signed [auo_pkg::ACC_W-1:0]   unw_acc;
   logic                               scl_valid, scl_ready;
   auo_pkg::scaled_type                scl_data;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= auo_pkg::THRESH_RESET;
         offset_ff <= auo_pkg::OFFSET_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            auo_pkg::CSR_JUMP_THRESHOLD: begin
               thresh_ff <= csr_ch.data[auo_pkg::THRESH_W-1:0];
            end
            auo_pkg::CSR_POSITION_OFFSET: begin
               offset_ff <= csr_ch.data[auo_pkg::OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   auo_unwrap u_unwrap (
      .clock     (clock),
      .reset     (reset),
      .thresh    (thresh_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_sample (req_ch.angle_sample),
      .out_valid (unw_valid),
      .out_ready (unw_ready),
      .out_acc   (unw_acc)
   );

   auo_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .offset    (offset_ff),
      .in_valid  (unw_valid),
      .in_ready  (unw_ready),
      .in_acc    (unw_acc),
      .out_valid (scl_valid),
      .out_ready (scl_ready),
      .out_data  (scl_data)
   );

   auo_digits u_digits (
      .clock    (clock),
      .reset    (reset),
      .in_valid (scl_valid),
      .in_ready (scl_ready),
      .in_data  (scl_data),
      .rsp      (rsp_ch)
   );
endmodule

// File: src/auo_checker.sv
// Port-level checks on the odometer result channel, bound to the top level.
module auo_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [auo_pkg::POS_W-1:0]   rsp_position,
   input logic [auo_pkg::DIGIT_W-1:0]        rsp_low,
   input logic [auo_pkg::DIGIT_W-1:0]        rsp_high
);
   // A result beat that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_low) && $stable(rsp_high))
      else $error("result beat changed while stalled");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position <= 16'sd20000) && (rsp_position >= -16'sd20000))
      else $error("position outside saturation limits");

   a_low_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_low < auo_pkg::DIGIT_BASE)
      else $error("low digit not below the digit base");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind angle_unwrap_odometer auo_checker u_auo_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_position (rsp_ch.position),
   .rsp_low      (rsp_ch.frame_low_digit),
   .rsp_high     (rsp_ch.frame_high_digit)
);

// File: sim/auo_odometer_checker.sv
// Checker that predicts every odometer result beat and compares it with the block's output.
`timescale 1ns / 100ps

module auo_odometer_checker (
   input  logic clock,
   input  logic reset,
   auo_req_if   req_mon,
   auo_rsp_if   rsp_mon,
   auo_csr_if   csr_mon,
   output int   mismatches,
   output int   awaiting
);
   localparam int     ANGLE_W       = auo_pkg::ANGLE_W;
   localparam int     THRESH_W      = auo_pkg::THRESH_W;
   localparam int     OFFSET_W      = auo_pkg::OFFSET_W;
   localparam int     POS_W         = auo_pkg::POS_W;
   localparam int     DIGIT_W       = auo_pkg::DIGIT_W;

   localparam int     RESET_JUMP    = 3000;
   localparam int     RESET_OFFSET  = 20000;
   localparam longint FULL_TURN     = 4096;
   localparam longint RATIO_NUM     = 1000;
   localparam longint RATIO_DEN     = 25129;
   localparam longint POSITION_CAP  = 20000;
   localparam longint FRAME_CAP     = 51199;
   localparam longint DIGIT_RADIX   = 200;
   localparam longint TURN_MAX      = 64'sd2147483647;
   localparam longint TURN_MIN      = -64'sd2147483648;

   typedef struct {
      logic signed [POS_W-1:0] position;
      logic [DIGIT_W-1:0]      low_digit;
      logic [DIGIT_W-1:0]      high_digit;
   } reading_type;

   reading_type          reading_q[$];
   logic [THRESH_W-1:0]  jump_thresh;
   logic [OFFSET_W-1:0]  frame_offset;
   logic                 seen_first;
   logic [ANGLE_W-1:0]   last_angle;
   int                   turn_count;
   int                   fail_tally;

   // Unwraps one sample into the turn count and forms the reading it produces.
   function automatic reading_type advance_odometer(input logic [ANGLE_W-1:0] sample);
      longint      step;
      longint      mag;
      longint      thresh;
      longint      sum;
      longint      scaled;
      longint      framed;
      reading_type r;
      thresh = jump_thresh;
      framed = frame_offset;
      if (!seen_first) begin
         seen_first = 1'b1;
         turn_count = 0;
      end else begin
         step = $signed({1'b0, sample}) - $signed({1'b0, last_angle});
         mag  = (step < 0) ? -step : step;
         if (step != 0) begin
            // A step at or beyond the threshold is a crossing of the zero point.
            if (mag >= thresh) begin
               if (step > 0) step = step - FULL_TURN;
               else step = step + FULL_TURN;
            end
            sum = longint'(turn_count) + step;
            if (sum > TURN_MAX) sum = TURN_MAX;
            if (sum < TURN_MIN) sum = TURN_MIN;
            turn_count = int'(sum);
         end
      end
      last_angle = sample;
      scaled = (longint'(turn_count) * RATIO_NUM) / RATIO_DEN;
      if (scaled > POSITION_CAP) scaled = POSITION_CAP;
      if (scaled < -POSITION_CAP) scaled = -POSITION_CAP;
      framed = framed + scaled;
      if (framed < 0) framed = 0;
      if (framed > FRAME_CAP) framed = FRAME_CAP;
      r.position   = scaled[POS_W-1:0];
      r.low_digit  = DIGIT_W'(framed % DIGIT_RADIX);
      r.high_digit = DIGIT_W'(framed / DIGIT_RADIX);
      return r;
   endfunction

   function automatic void check_field(input string field, input longint want,
                                       input longint got);
      if (want != got) begin
         fail_tally++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   initial fail_tally = 0;

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         jump_thresh  = THRESH_W'(RESET_JUMP);
         frame_offset = OFFSET_W'(RESET_OFFSET);
         seen_first   = 1'b0;
         last_angle   = '0;
         turn_count   = 0;
         reading_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               auo_pkg::CSR_JUMP_THRESHOLD: begin
                  jump_thresh = csr_mon.data[THRESH_W-1:0];
               end
               auo_pkg::CSR_POSITION_OFFSET: begin
                  frame_offset = csr_mon.data[OFFSET_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // A result always leaves after its own sample was taken, so match before pushing.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reading_q.size() == 0) begin
               fail_tally++;
               $display("%0t: result beat with none expected, position %0d", $time,
                        rsp_mon.position);
            end else begin
               want = reading_q.pop_front();
               check_field("position", want.position, rsp_mon.position);
               check_field("frame_low_digit", want.low_digit, rsp_mon.frame_low_digit);
               check_field("frame_high_digit", want.high_digit, rsp_mon.frame_high_digit);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            reading_q.push_back(advance_odometer(req_mon.angle_sample));
         end
      end
      mismatches <= fail_tally;
      awaiting   <= reading_q.size();
   end

endmodule

// File: sim/tb_angle_unwrap_odometer.sv
// Stimulus and verdict for the angle unwrap odometer regression.
`timescale 1ns / 100ps

module tb_angle_unwrap_odometer;
   localparam int ANGLE_W         = auo_pkg::ANGLE_W;
   localparam int CSR_IDX_W       = auo_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W       = auo_pkg::CSR_DAT_W;

   localparam int MAX_GAP         = 12;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_TWO   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_THREE = 2'd3;

   typedef enum {SWEEP_WANDER, SWEEP_SPIN_DOWN, SWEEP_SPIN_UP, SWEEP_SCATTER} sweep_kind_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   bit                 sender_lazy;
   bit                 receiver_lazy;
   bit                 stall_request;
   int                 idle_cycles = 0;
   int                 mismatches;
   int                 awaiting;
   logic [ANGLE_W-1:0] last_sent;

   auo_req_if req_ch();
   auo_rsp_if rsp_ch();
   auo_csr_if csr_ch();

   angle_unwrap_odometer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   auo_odometer_checker odometer_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always #5 clock = ~clock;

   task automatic offer_sample(input logic [ANGLE_W-1:0] sample);
      int gap;
      gap = sender_lazy ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.angle_sample <= sample;
      last_sent = sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Stops offering samples and waits until every result beat has come back.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic configure(input int thresh, input int offset);
      settle();
      write_register(auo_pkg::CSR_JUMP_THRESHOLD, CSR_DAT_W'(thresh));
      write_register(auo_pkg::CSR_POSITION_OFFSET, CSR_DAT_W'(offset));
      sender_lazy   = ($urandom_range(0, 3) != 0);
      receiver_lazy = ($urandom_range(0, 3) != 0);
   endtask

   // With a threshold of one, every small forward step counts as a backward
   // turn and every small backward step as a forward turn, which drives the
   // position into saturation quickly.
   task automatic run_sweep(input sweep_kind_type kind, input int count);
      logic [ANGLE_W-1:0] sample;
      for (int i = 0; i < count; i++) begin
         case (kind)
            SWEEP_WANDER: begin
               if ($urandom_range(0, 7) == 0) sample = ANGLE_W'($urandom_range(0, 4095));
               else sample = last_sent + ANGLE_W'($urandom_range(0, 800)) - ANGLE_W'(400);
            end
            SWEEP_SPIN_DOWN: begin
               sample = last_sent + ANGLE_W'($urandom_range(1, 8));
            end
            SWEEP_SPIN_UP: begin
               sample = last_sent - ANGLE_W'($urandom_range(1, 8));
            end
            default: begin
               sample = ANGLE_W'($urandom_range(0, 4095));
            end
         endcase
         offer_sample(sample);
      end
   endtask

   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end else begin
            gap = receiver_lazy ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
         $display("angle_unwrap_odometer regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.angle_sample = '0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = auo_pkg::CSR_JUMP_THRESHOLD;
      csr_ch.data         = '0;
      last_sent           = '0;
      sender_lazy         = 1'b1;
      receiver_lazy       = 1'b1;
      stall_request       = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: priming, a repeated sample, a wrap of one count,
      // a step exactly at the threshold and one just inside it.
      offer_sample(12'hFFF);
      offer_sample(12'hFFF);
      offer_sample(12'h000);
      offer_sample(12'd3000);
      offer_sample(12'd1);
      offer_sample(12'hAAA);
      offer_sample(12'h555);

      // Widest threshold, no offset: a full-range step sits on the threshold.
      configure(4095, 0);
      write_register(CSR_SPARE_TWO, CSR_DAT_W'($urandom));
      write_register(CSR_SPARE_THREE, CSR_DAT_W'($urandom));
      offer_sample(12'h000);
      offer_sample(12'hFFF);
      offer_sample(12'd1);
      offer_sample(12'h800);

      // Narrowest threshold, largest offset this regression uses: any nonzero step is a wrap.
      configure(1, 25535);
      offer_sample(12'd5);
      offer_sample(12'd5);
      offer_sample(12'd6);
      offer_sample(12'd4);
      offer_sample(12'h7FF);

      configure(2048, 12345);
      offer_sample(12'd0);
      offer_sample(12'd2048);
      offer_sample(12'd1);

      configure($urandom_range(1, 4095), $urandom_range(0, 25535));
      run_sweep(SWEEP_WANDER, 30);
      configure(1, $urandom_range(0, 5000));
      run_sweep(SWEEP_SPIN_DOWN, 128);
      configure(4095, 25535);
      run_sweep(SWEEP_SCATTER, 25);
      configure(1, $urandom_range(0, 25535));
      stall_request = 1'b1;
      run_sweep(SWEEP_SPIN_UP, 150);
      configure($urandom_range(1, 4095), $urandom_range(0, 25535));
      run_sweep(SWEEP_WANDER, 25);
      configure($urandom_range(1, 4095), $urandom_range(0, 25535));
      run_sweep(SWEEP_SCATTER, 25);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("angle_unwrap_odometer regression: pass");
      end else begin
         if (awaiting != 0) $display("%0t: %0d result beats never arrived", $time, awaiting);
         $display("angle_unwrap_odometer regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
src/auo_pkg.sv
src/auo_if.sv
src/auo_unwrap.sv
src/auo_scale.sv
src/auo_digits.sv
src/angle_unwrap_odometer.sv
src/auo_checker.sv
sim/auo_odometer_checker.sv
sim/tb_angle_unwrap_odometer.sv
